>>> design/lius_pkg.sv
// Package for the linear interpolation upsampler.
// Holds fixed widths, constants, ALU request type and sequencer states.
// No dependencies.
package lius_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int STEP_W      = 28;
    localparam int SCALE_SHIFT = 12;
    localparam int OUT_SHIFT   = 8;
    localparam int SCALED_W    = SAMPLE_W + SCALE_SHIFT;
    // one extra bit holds a difference of two scaled samples
    localparam int ACC_W       = SCALED_W + 1;
    localparam int BIT_W       = $clog2(ACC_W + 1);

    localparam logic [STEP_W-1:0] STEP_RESET = 28'd92484403;
    localparam int SAT_MAX = 32767;
    localparam int SAT_MIN = -32768;

    typedef enum logic [0:0] {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    typedef struct packed {
        t_alu_op          op;
        logic [ACC_W-1:0] a;
        logic [ACC_W-1:0] b;
    } t_alu_req;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIFF,
        S_ABS,
        S_DIV,
        S_SIGN,
        S_EMIT
    } t_state;

endpackage

>>> design/lius_stream_if.sv
// Stream interfaces for the upsampler input and output channels.
// Depends on lius_pkg for the payload widths.
interface lius_in_if import lius_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface lius_out_if import lius_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       last;

    modport source (output valid, output sample_out, output last, input ready);
    modport sink   (input valid, input sample_out, input last, output ready);
endinterface

>>> design/linear_interp_upsampler_top.sv
// Top level of the linear interpolation upsampler.
// Depends on lius_pkg, lius_in_if / lius_out_if and lius_alu.
//
// Channel   Direction  Payload               Transfer
// i_in      in         sample_in[15:0]       valid && ready
// o_out     out        sample_out[15:0],last valid && ready
// i_cfg_*   in         phase_step[27:0]      i_cfg_we
//
// An input with a zero phase carry is taken and emits nothing. Otherwise it
// passes through the states DIFF, ABS, DIV, SIGN and EMIT: the restoring
// divider produces one quotient bit per cycle through the shared adder, then
// one output per cycle while o_out.ready is high. Reset is synchronous, active
// low, and restores phase_step; the input is not ready while an item is at work.
module linear_interp_upsampler_top import lius_pkg::*; #(
    parameter int PHASE_BITS = 24,
    parameter int MAX_RATIO  = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [STEP_W-1:0] i_cfg_data,
    lius_in_if.sink           i_in,
    lius_out_if.source        o_out
);

    localparam int SUM_W = ((PHASE_BITS > STEP_W) ? PHASE_BITS : STEP_W) + 1;
    localparam int CAR_W = SUM_W - PHASE_BITS;
    localparam int CNT_W = $clog2(MAX_RATIO + 1);
    localparam int CMP_W = (CAR_W > CNT_W) ? CAR_W : CNT_W;
    localparam logic [CMP_W-1:0] CNT_MAX = CMP_W'(MAX_RATIO);
    localparam logic signed [ACC_W-1:0] HI = ACC_W'(SAT_MAX);
    localparam logic signed [ACC_W-1:0] LO = ACC_W'(SAT_MIN);

    t_state                r_state, n_state;
    logic [STEP_W-1:0]     r_step;
    logic [PHASE_BITS-1:0] r_frac, n_frac;
    logic [SCALED_W-1:0]   r_prev, n_prev;
    logic [SCALED_W-1:0]   r_sample, n_sample;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [ACC_W-1:0]      r_num, n_num;
    logic [CNT_W-1:0]      r_rem, n_rem;
    logic                  r_neg, n_neg;
    logic [BIT_W-1:0]      r_bits, n_bits;
    logic [ACC_W-1:0]      r_delta, n_delta;
    logic [ACC_W-1:0]      r_acc, n_acc;
    logic [CNT_W-1:0]      r_idx, n_idx;

    t_alu_req              alu_req;
    logic [ACC_W-1:0]      alu_y;
    logic [SUM_W-1:0]      sum;
    logic [CMP_W-1:0]      carry;
    logic [CNT_W-1:0]      cnt_next;
    logic [SCALED_W-1:0]   scaled_in;
    logic [CNT_W:0]        rem_sh;
    logic                  q_bit;
    logic                  in_fire;
    logic                  out_fire;
    logic                  is_last;
    logic signed [ACC_W-1:0] shifted;

    lius_alu u_alu (
        .i_req (alu_req),
        .o_y   (alu_y)
    );

    // phase advance and output count for the offered sample
    assign sum       = SUM_W'(r_frac) + SUM_W'(r_step);
    assign carry     = CMP_W'(sum[SUM_W-1:PHASE_BITS]);
    assign cnt_next  = (carry > CNT_MAX) ? CNT_W'(CNT_MAX) : CNT_W'(carry);
    assign scaled_in = {i_in.sample_in, {SCALE_SHIFT{1'b0}}};

    assign rem_sh   = {r_rem, r_num[ACC_W-1]};
    assign q_bit    = !alu_y[ACC_W-1];
    assign in_fire  = i_in.valid && i_in.ready;
    assign out_fire = o_out.valid && o_out.ready;
    assign is_last  = (r_idx == r_count - CNT_W'(1));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire && cnt_next != '0) n_state = S_DIFF;
            end
            S_DIFF: n_state = S_ABS;
            S_ABS:  n_state = S_DIV;
            S_DIV: begin
                if (r_bits == BIT_W'(1)) n_state = S_SIGN;
            end
            S_SIGN: n_state = S_EMIT;
            S_EMIT: begin
                if (out_fire && is_last) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        i_in.ready  = 1'b0;
        o_out.valid = 1'b0;
        case (r_state)
            S_IDLE:  i_in.ready  = 1'b1;
            S_EMIT:  o_out.valid = 1'b1;
            default: begin
                i_in.ready  = 1'b0;
                o_out.valid = 1'b0;
            end
        endcase
    end

    // saturate the floor-shifted accumulator
    always_comb begin
        shifted = signed'(r_acc) >>> OUT_SHIFT;
        if (shifted > HI)      o_out.sample_out = SAMPLE_W'(SAT_MAX);
        else if (shifted < LO) o_out.sample_out = SAMPLE_W'(SAT_MIN);
        else                   o_out.sample_out = shifted[SAMPLE_W-1:0];
        o_out.last = is_last;
    end

    // datapath control and shared ALU operands
    always_comb begin
        n_frac   = r_frac;
        n_prev   = r_prev;
        n_sample = r_sample;
        n_count  = r_count;
        n_num    = r_num;
        n_rem    = r_rem;
        n_neg    = r_neg;
        n_bits   = r_bits;
        n_delta  = r_delta;
        n_acc    = r_acc;
        n_idx    = r_idx;
        alu_req  = '{op: ALU_ADD, a: r_acc, b: r_delta};
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_frac   = sum[PHASE_BITS-1:0];
                    n_sample = scaled_in;
                    n_count  = cnt_next;
                    // no outputs: take the sample as the new reference now
                    if (cnt_next == '0) n_prev = scaled_in;
                end
            end
            S_DIFF: begin
                alu_req = '{op: ALU_SUB,
                            a: {r_sample[SCALED_W-1], r_sample},
                            b: {r_prev[SCALED_W-1], r_prev}};
                n_num = alu_y;
            end
            S_ABS: begin
                // take the magnitude, remember the sign
                alu_req = '{op: ALU_SUB, a: '0, b: r_num};
                n_neg   = r_num[ACC_W-1];
                if (r_num[ACC_W-1]) n_num = alu_y;
                n_rem   = '0;
                n_bits  = BIT_W'(ACC_W);
            end
            S_DIV: begin
                // one restoring step: trial subtract, keep or restore
                alu_req = '{op: ALU_SUB, a: ACC_W'(rem_sh), b: ACC_W'(r_count)};
                n_rem   = q_bit ? alu_y[CNT_W-1:0] : rem_sh[CNT_W-1:0];
                n_num   = {r_num[ACC_W-2:0], q_bit};
                n_bits  = r_bits - BIT_W'(1);
            end
            S_SIGN: begin
                alu_req = '{op: ALU_SUB, a: '0, b: r_num};
                n_delta = r_neg ? alu_y : r_num;
                n_acc   = {r_prev[SCALED_W-1], r_prev};
                n_idx   = '0;
            end
            S_EMIT: begin
                alu_req = '{op: ALU_ADD, a: r_acc, b: r_delta};
                if (out_fire) begin
                    n_acc = alu_y;
                    n_idx = r_idx + CNT_W'(1);
                    if (is_last) n_prev = r_sample;
                end
            end
            default: begin
                n_idx = '0;
            end
        endcase
    end

    // control state and phase register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= STEP_RESET;
            r_frac  <= '0;
            r_prev  <= '0;
            r_bits  <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_step <= i_cfg_data;
            r_frac  <= n_frac;
            r_prev  <= n_prev;
            r_bits  <= n_bits;
            r_idx   <= n_idx;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_sample <= n_sample;
        r_count  <= n_count;
        r_num    <= n_num;
        r_rem    <= n_rem;
        r_neg    <= n_neg;
        r_delta  <= n_delta;
        r_acc    <= n_acc;
    end

`ifndef SYNTHESIS
    a_ready_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !o_out.valid)
        else $error("input ready while an output is offered");

    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && o_out.last) |=> i_in.ready)
        else $error("block not ready after the last output transfer");

    a_div_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_bits != '0))
        else $error("divider running with no bits left");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (r_idx < r_count))
        else $error("output index beyond the count");

    a_count_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIFF) |-> (r_count != '0))
        else $error("interpolation started with a zero count");
`endif

endmodule

>>> design/lius_alu.sv
// Shared add/subtract unit of the upsampler sequencer.
// Depends on lius_pkg for the request type.
module lius_alu import lius_pkg::*; (
    input  t_alu_req         i_req,
    output logic [ACC_W-1:0] o_y
);

    // add or subtract the two operands
    always_comb begin
        case (i_req.op)
            ALU_ADD: o_y = i_req.a + i_req.b;
            ALU_SUB: o_y = i_req.a - i_req.b;
            default: o_y = i_req.a;
        endcase
    end

endmodule

>>> tb/linear_interp_upsampler_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for linear_interp_upsampler_top: table-driven directed
// samples, then random phase steps and samples, checked against an inline predictor.
// Depends on lius_pkg, lius_in_if / lius_out_if and the upsampler RTL.
module linear_interp_upsampler_top_tb;
    import lius_pkg::*;

    localparam int PHASE_FRAC      = 24;
    localparam int RATIO_CAP       = 16;
    localparam logic [STEP_W-1:0] STEP_ONE  = 28'h100_0000;
    localparam logic [STEP_W-1:0] STEP_MAX  = 28'hFFF_FFFF;
    localparam logic [STEP_W-1:0] STEP_HALF = 28'h080_0000;
    // divider plus a full burst of outputs, with margin
    localparam int SETTLE_CYCLES   = 64;
    localparam int CYCLE_LIMIT     = 800000;
    localparam int RAND_PHASES     = 9;
    localparam int ITEMS_PER_PHASE = 28;
    localparam int MAX_PRINTS      = 100;
    localparam int N_DIR           = 26;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } t_out_item;

    typedef enum logic {
        ROW_STEP,
        ROW_SAMPLE
    } t_row_kind;

    // typed rows: n_out outputs, all equal to out_val
    typedef struct {
        t_row_kind kind;
        int        value;
        bit        typed;
        int        n_out;
        int        out_val;
    } t_stim_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [STEP_W-1:0] i_cfg_data;

    lius_in_if  in_ch ();
    lius_out_if out_ch ();

    linear_interp_upsampler_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    // Predictor state and the outputs still owed by the block
    logic [STEP_W-1:0]            step_model;
    logic [PHASE_FRAC-1:0]        frac_model;
    logic signed [SCALED_W-1:0]   prev_model;
    t_out_item                    samples_due[$];
    t_out_item                    fresh_outs[$];
    int                           err_count   = 0;
    int                           cycle_count = 0;
    int                           burst_left  = 0;

    // Directed table: reset step, unit step (output is previous sample times 16),
    // maximum step, fractional step with zero-carry inputs, and zero step.
    t_stim_row dir_rows [N_DIR] = '{
        '{ROW_SAMPLE,      0, 1'b1, 5,      0},
        '{ROW_SAMPLE,  32767, 1'b0, 0,      0},
        '{ROW_SAMPLE, -32768, 1'b0, 0,      0},
        '{ROW_SAMPLE,      0, 1'b0, 0,      0},
        '{ROW_STEP,   int'(STEP_ONE), 1'b0, 0, 0},
        '{ROW_SAMPLE,      1, 1'b1, 1,      0},
        '{ROW_SAMPLE,  32767, 1'b1, 1,     16},
        '{ROW_SAMPLE, -32768, 1'b1, 1,  32767},
        '{ROW_SAMPLE,   2048, 1'b1, 1, -32768},
        '{ROW_SAMPLE,     -1, 1'b1, 1,  32767},
        '{ROW_SAMPLE,  -2049, 1'b1, 1,    -16},
        '{ROW_SAMPLE,  21845, 1'b1, 1, -32768},
        '{ROW_SAMPLE, -21846, 1'b1, 1,  32767},
        '{ROW_SAMPLE,      0, 1'b1, 1, -32768},
        '{ROW_STEP,   int'(STEP_MAX), 1'b0, 0, 0},
        '{ROW_SAMPLE,  32767, 1'b0, 0,      0},
        '{ROW_SAMPLE, -32768, 1'b0, 0,      0},
        '{ROW_SAMPLE,      1, 1'b0, 0,      0},
        '{ROW_STEP,   int'(STEP_HALF), 1'b0, 0, 0},
        '{ROW_SAMPLE,   1000, 1'b0, 0,      0},
        '{ROW_SAMPLE,  -1000, 1'b0, 0,      0},
        '{ROW_SAMPLE,      5, 1'b0, 0,      0},
        '{ROW_SAMPLE,      7, 1'b0, 0,      0},
        '{ROW_STEP,   0,      1'b0, 0,      0},
        '{ROW_SAMPLE,    123, 1'b1, 0,      0},
        '{ROW_SAMPLE,     -5, 1'b1, 0,      0}
    };

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Count every mismatch, print only the first ones
    task automatic flag_mismatch(input string msg);
        err_count++;
        if (err_count <= MAX_PRINTS)
            $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    // Advance the phase, then interpolate from the previous scaled sample to this one
    task automatic interpolate_input(input logic signed [SAMPLE_W-1:0] s);
        logic [PHASE_FRAC+4:0] sum;
        int                    count;
        longint                scaled;
        longint                delta;
        longint                v;
        longint                q;
        t_out_item             item;
        fresh_outs.delete();
        sum = {5'd0, frac_model} + {1'b0, step_model};
        count = int'(sum[PHASE_FRAC +: 5]);
        if (count > RATIO_CAP)
            count = RATIO_CAP;
        frac_model = sum[PHASE_FRAC-1:0];
        scaled = longint'(s) * (longint'(1) << SCALE_SHIFT);
        if (count != 0) begin
            // signed division truncates toward zero, arithmetic shift floors
            delta = (scaled - longint'(prev_model)) / count;
            for (int i = 0; i < count; i++) begin
                v = longint'(prev_model) + i * delta;
                q = v >>> OUT_SHIFT;
                if (q > SAT_MAX)
                    q = SAT_MAX;
                if (q < SAT_MIN)
                    q = SAT_MIN;
                item.sample = q[SAMPLE_W-1:0];
                item.last   = (i == count - 1);
                fresh_outs.push_back(item);
            end
        end
        prev_model = scaled[SCALED_W-1:0];
    endtask

    // Present one sample in bursts with random gaps; queue its outputs on transfer
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input bit typed,
                               input int n_out, input int out_val);
        int        gap;
        t_out_item item;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 5) == 0) ? $urandom_range(6, 25) : $urandom_range(0, 3);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        in_ch.valid     <= 1'b1;
        in_ch.sample_in <= s;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        burst_left--;
        interpolate_input(s);
        if (typed) begin
            for (int i = 0; i < n_out; i++) begin
                item.sample = SAMPLE_W'(out_val);
                item.last   = (i == n_out - 1);
                samples_due.push_back(item);
            end
        end else begin
            foreach (fresh_outs[i])
                samples_due.push_back(fresh_outs[i]);
        end
    endtask

    // Hold the input idle until all outputs are back and the block has gone quiet
    task automatic drain_and_settle();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        while (samples_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_step(input logic [STEP_W-1:0] v);
        drain_and_settle();
        i_cfg_data <= v;
        i_cfg_we   <= 1'b1;
        @(posedge i_clk);
        step_model = v;
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return SAMPLE_W'($urandom);
            // around the gain-16 saturation threshold
            5, 6:          return SAMPLE_W'($urandom_range(0, 4200) - 2100);
            7:             return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            default:       return SAMPLE_W'($urandom_range(0, 128) - 64);
        endcase
    endfunction

    // Output side stalls in modes that are picked anew at random
    initial begin : receiver
        int mode       = 0;
        int hold       = 0;
        int phase_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (phase_left == 0) begin
                mode       = $urandom_range(0, 3);
                phase_left = $urandom_range(50, 300);
            end
            phase_left--;
            case (mode)
                0: out_ch.ready <= 1'b1;
                1: out_ch.ready <= ($urandom_range(0, 1) == 1);
                2: out_ch.ready <= (phase_left % 4 == 0);
                default: begin
                    if (hold > 0) begin
                        hold--;
                        out_ch.ready <= 1'b0;
                    end else begin
                        out_ch.ready <= 1'b1;
                        if ($urandom_range(0, 3) == 0)
                            hold = $urandom_range(5, 20);
                    end
                end
            endcase
        end
    end

    // Compare each output transfer with the oldest expectation
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (samples_due.size() == 0) begin
                flag_mismatch($sformatf("unexpected output sample %0d last %0b",
                                        out_ch.sample_out, out_ch.last));
            end else begin
                want = samples_due.pop_front();
                if (out_ch.sample_out !== want.sample)
                    flag_mismatch($sformatf("sample_out %0d, expected %0d",
                                            out_ch.sample_out, want.sample));
                if (out_ch.last !== want.last)
                    flag_mismatch($sformatf("last %0b, expected %0b (sample %0d)",
                                            out_ch.last, want.last, want.sample));
            end
        end
    end

    initial begin : stimulus
        logic [STEP_W-1:0] step;
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_data      <= '0;
        in_ch.valid     <= 1'b0;
        in_ch.sample_in <= '0;
        step_model = STEP_RESET;
        frac_model = '0;
        prev_model = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table
        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_STEP)
                write_step(STEP_W'(dir_rows[r].value));
            else
                send_sample(SAMPLE_W'(dir_rows[r].value), dir_rows[r].typed,
                            dir_rows[r].n_out, dir_rows[r].out_val);
        end

        // Random phases, each with its own rate ratio
        for (int p = 0; p < RAND_PHASES; p++) begin
            case ($urandom_range(0, 7))
                0:       step = STEP_RESET;
                1:       step = STEP_ONE;
                2:       step = STEP_MAX;
                3, 4:    step = STEP_W'($urandom_range(STEP_ONE, STEP_MAX));
                5:       step = STEP_W'($urandom_range(STEP_ONE, 28'h3FF_FFFF));
                6:       step = STEP_W'($urandom_range(0, STEP_ONE - 1));
                default: step = STEP_W'($urandom);
            endcase
            write_step(step);
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
                send_sample(pick_sample(), 1'b0, 0, 0);
        end

        drain_and_settle();
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
